[rtl/core/nfp_pkg.sv]
// nfp_pkg: shared constants, codes and types for the navigation frame parser.
// No dependencies; imported by nfp_field_buf and nav_frame_parser.
package nfp_pkg;

    // Frame header bytes
    localparam logic [7:0] SYNC_A    = 8'hB5;
    localparam logic [7:0] SYNC_B    = 8'h62;
    localparam logic [7:0] CLASS_NAV = 8'h01;
    localparam logic [7:0] ID_PVT    = 8'h07;

    // Frame positions
    localparam int unsigned POS_CLASS = 2;
    localparam int unsigned POS_LEN   = 4;
    localparam int unsigned POS_BODY  = 5;

    // Span of frame positions that feed extracted values
    localparam int unsigned FIELD_LO    = 27;
    localparam int unsigned FIELD_HI    = 83;
    localparam int unsigned FIELD_BYTES = FIELD_HI - FIELD_LO + 1;
    localparam int unsigned FIELD_OFS_W = $clog2(FIELD_BYTES);

    // Length arithmetic: length byte plus header and checksum bytes
    localparam int unsigned LEN_EXT_W = 9;

    localparam logic [6:0] MAX_LENGTH_RESET = 7'd100;

    // Result index codes
    typedef enum logic [3:0] {
        FLD_FLAGS    = 4'd0,
        FLD_NUM_SV   = 4'd1,
        FLD_LON      = 4'd2,
        FLD_LAT      = 4'd3,
        FLD_HMSL     = 4'd4,
        FLD_HACC     = 4'd5,
        FLD_VACC     = 4'd6,
        FLD_VEL_N    = 4'd7,
        FLD_VEL_E    = 4'd8,
        FLD_GSPEED   = 4'd9,
        FLD_HEADING  = 4'd10,
        FLD_SACC     = 4'd11,
        FLD_HEAD_ACC = 4'd12,
        FLD_PDOP     = 4'd13,
        FLD_COUNT    = 4'd14
    } t_fld_idx;

    // Write of one received byte into the extracted-field byte registers
    typedef struct packed {
        logic                   en;
        logic [FIELD_OFS_W-1:0] ofs;
        logic [7:0]             data;
    } t_fld_wr;

    // Expected header byte at sync positions 0..3
    function automatic logic [7:0] sync_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = SYNC_A;
            2'd1:    b = SYNC_B;
            2'd2:    b = CLASS_NAV;
            default: b = ID_PVT;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/nfp_field_buf.sv]
// nfp_field_buf: byte registers for frame positions 27..83 and the result drain.
// Depends on nfp_pkg (t_fld_wr, t_fld_idx, field span constants).
module nfp_field_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nfp_pkg::t_fld_wr i_wr,
    input  logic            i_start,
    input  logic [31:0]     i_count,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [3:0]      o_field_index,
    output logic [31:0]     o_field_value,
    output logic            o_last_field
);
    import nfp_pkg::*;

    localparam int unsigned FLAT_W = (FIELD_BYTES + 3) * 8;

    logic [7:0]        r_fb [FIELD_BYTES];
    logic              r_busy;
    t_fld_idx          r_idx;
    logic [FLAT_W-1:0] w_flat;

    // Field bytes: zero after reset, then hold the last byte seen at each position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FIELD_BYTES; i++) r_fb[i] <= 8'd0;
        end else if (i_wr.en) begin
            r_fb[i_wr.ofs] <= i_wr.data;
        end
    end

    // Drain fifteen results, one per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= FLD_FLAGS;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= FLD_FLAGS;
        end else if (r_busy && i_ready) begin
            if (r_idx == FLD_COUNT) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= t_fld_idx'(r_idx + 4'd1);
            end
        end
    end

    // Little-endian byte image; pad past the top so word selects stay in range
    always_comb begin
        w_flat = '0;
        for (int i = 0; i < FIELD_BYTES; i++) w_flat[i*8 +: 8] = r_fb[i];
    end

    always_comb begin
        case (r_idx)
            FLD_FLAGS:    o_field_value = {24'd0, w_flat[(27-FIELD_LO)*8 +: 8]};
            FLD_NUM_SV:   o_field_value = {24'd0, w_flat[(29-FIELD_LO)*8 +: 8]};
            FLD_LON:      o_field_value = w_flat[(30-FIELD_LO)*8 +: 32];
            FLD_LAT:      o_field_value = w_flat[(34-FIELD_LO)*8 +: 32];
            FLD_HMSL:     o_field_value = w_flat[(42-FIELD_LO)*8 +: 32];
            FLD_HACC:     o_field_value = w_flat[(46-FIELD_LO)*8 +: 32];
            FLD_VACC:     o_field_value = w_flat[(50-FIELD_LO)*8 +: 32];
            FLD_VEL_N:    o_field_value = w_flat[(54-FIELD_LO)*8 +: 32];
            FLD_VEL_E:    o_field_value = w_flat[(58-FIELD_LO)*8 +: 32];
            FLD_GSPEED:   o_field_value = w_flat[(66-FIELD_LO)*8 +: 32];
            FLD_HEADING:  o_field_value = w_flat[(70-FIELD_LO)*8 +: 32];
            FLD_SACC:     o_field_value = w_flat[(74-FIELD_LO)*8 +: 32];
            FLD_HEAD_ACC: o_field_value = w_flat[(78-FIELD_LO)*8 +: 32];
            FLD_PDOP:     o_field_value = {16'd0, w_flat[(82-FIELD_LO)*8 +: 16]};
            FLD_COUNT:    o_field_value = i_count;
            default:      o_field_value = 32'd0;
        endcase
    end

    assign o_valid       = r_busy;
    assign o_field_index = r_idx;
    assign o_last_field  = (r_idx == FLD_COUNT);

endmodule

[rtl/core/nav_frame_parser.sv]
// nav_frame_parser: top level of the byte-serial position frame parser.
// Depends on nfp_pkg and nfp_field_buf.
//
//  channel   ports                                      direction
//  ------    -----------------------------------------  ---------
//  rx byte   i_valid, o_ready, i_rx_byte                in
//  result    o_valid, i_ready, o_field_index,           out
//            o_field_value, o_last_field
//  config    i_cfg_we, i_cfg_data (max_length)          in
//
// One byte transfers per cycle while o_ready is high; parse, running checksum
// and field write finish in that cycle. The second checksum byte of a good
// frame starts a run of fifteen results, the first on the next cycle. During
// a run, bytes flow until position 27 (first byte that feeds a result) or a
// frame end, then stall.
// Synchronous reset clears parse state, count and field bytes; max_length = 100.
module nav_frame_parser #(
    parameter int unsigned STORE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_field_index,
    output logic [31:0] o_field_value,
    output logic        o_last_field,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data
);
    import nfp_pkg::*;

    localparam int unsigned PW = $clog2(STORE_DEPTH + 1);

    logic [PW-1:0]  r_pos,       n_pos;
    logic [7:0]     r_len,       n_len;
    logic [7:0]     r_sum,       n_sum;
    logic [7:0]     r_ck,        n_ck;
    logic [31:0]    r_frame_cnt, n_frame_cnt;
    logic [6:0]     r_max_len;

    logic                 w_accept;
    logic                 w_final;
    logic                 w_start;
    logic [LEN_EXT_W-1:0] w_pos_ext;
    logic [LEN_EXT_W-1:0] w_len_ext;
    logic [LEN_EXT_W-1:0] w_rx_ext;
    t_fld_wr              w_fld_wr;

    assign w_pos_ext = LEN_EXT_W'(r_pos);
    assign w_len_ext = LEN_EXT_W'(r_len);
    assign w_rx_ext  = LEN_EXT_W'(i_rx_byte);

    // Second checksum byte position: length + 7
    assign w_final = (r_pos >= PW'(POS_BODY)) && (w_pos_ext == w_len_ext + LEN_EXT_W'(7));

    // Hold input off when the next byte could disturb results still draining
    assign o_ready  = !o_valid || ((r_pos < PW'(FIELD_LO)) && !w_final);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        n_sum       = r_sum;
        n_ck        = r_ck;
        n_frame_cnt = r_frame_cnt;
        w_start     = 1'b0;
        w_fld_wr    = '0;
        if (w_accept) begin
            if (r_pos < PW'(POS_LEN)) begin
                // Sync hunt: drop back to position 0 on any mismatch
                if (i_rx_byte == sync_byte(r_pos[1:0])) begin
                    n_pos = r_pos + PW'(1);
                    if (r_pos == PW'(POS_CLASS)) begin
                        n_sum = i_rx_byte;
                    end else begin
                        n_sum = r_sum + i_rx_byte;
                    end
                end else begin
                    n_pos = '0;
                end
            end else if (r_pos == PW'(POS_LEN)) begin
                n_len = i_rx_byte;
                n_sum = r_sum + i_rx_byte;
                if ((i_rx_byte > {1'b0, r_max_len}) ||
                    (w_rx_ext + LEN_EXT_W'(7) > LEN_EXT_W'(STORE_DEPTH))) begin
                    n_pos = '0;
                end else begin
                    n_pos = PW'(POS_BODY);
                end
            end else if (w_final) begin
                // Frame end: compare running sum with first checksum byte
                n_pos = '0;
                if (r_sum == r_ck) begin
                    w_start     = 1'b1;
                    n_frame_cnt = r_frame_cnt + 32'd1;
                end
            end else begin
                n_pos = r_pos + PW'(1);
                if (w_pos_ext <= w_len_ext + LEN_EXT_W'(5)) begin
                    n_sum = r_sum + i_rx_byte;
                end else begin
                    n_ck = i_rx_byte;
                end
                if ((r_pos >= PW'(FIELD_LO)) && (r_pos <= PW'(FIELD_HI))) begin
                    w_fld_wr.en   = 1'b1;
                    w_fld_wr.ofs  = FIELD_OFS_W'(r_pos - PW'(FIELD_LO));
                    w_fld_wr.data = i_rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= 8'd0;
            r_sum       <= 8'd0;
            r_ck        <= 8'd0;
            r_frame_cnt <= 32'd0;
            r_max_len   <= MAX_LENGTH_RESET;
        end else begin
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_ck        <= n_ck;
            r_frame_cnt <= n_frame_cnt;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    nfp_field_buf u_field_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_fld_wr),
        .i_start       (w_start),
        .i_count       (r_frame_cnt),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_field_index (o_field_index),
        .o_field_value (o_field_value),
        .o_last_field  (o_last_field)
    );

    // A new result run never starts over one still draining
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !o_valid)
        else $error("result run started while previous run busy");

    // A good frame end presents the first result on the next cycle
    a_start_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (o_valid && (o_field_index == FLD_FLAGS)))
        else $error("frame end did not present first result");

    // Frame count moves only on a good frame end
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_start |=> $stable(r_frame_cnt))
        else $error("frame count changed without a good frame");

    // No field byte is written while results are draining
    a_no_field_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_fld_wr.en)
        else $error("field byte overwritten during result drain");

    // Position never runs past the store
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (w_pos_ext <= LEN_EXT_W'(STORE_DEPTH)))
        else $error("parse position beyond store depth");

endmodule

[tb/sv/nav_frame_parser_checker.sv]
`timescale 1ns / 1ps
// nav_frame_parser_checker: monitors the byte, result and config ports of the
// frame parser, predicts the extracted values and compares every result.
// Depends on nfp_pkg for header bytes and result index codes.
module nav_frame_parser_checker #(
    parameter int unsigned STORE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [3:0]  i_field_index,
    input  logic [31:0] i_field_value,
    input  logic        i_last_field,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import nfp_pkg::*;

    typedef struct packed {
        t_fld_idx    index;
        logic [31:0] value;
        logic        last;
    } t_field;

    // First frame position of each extracted value, index 0 in the low slice
    localparam logic [13:0][7:0] FIELD_START = {
        8'd82, 8'd78, 8'd74, 8'd70, 8'd66, 8'd58, 8'd54,
        8'd50, 8'd46, 8'd42, 8'd34, 8'd30, 8'd29, 8'd27
    };

    logic [7:0]  frame_bytes [STORE_DEPTH];
    int unsigned hunt_pos;
    int unsigned frame_len;
    logic [31:0] good_frames;
    logic [6:0]  len_limit;
    t_field      expected_fields [$];
    int          errors = 0;

    function automatic logic [31:0] le_value(input int unsigned pos, input int nbytes);
        logic [31:0] v;
        int i;
        v = '0;
        for (i = nbytes - 1; i >= 0; i--)
            v = (v << 8) | 32'(frame_bytes[pos + i]);
        return v;
    endfunction

    function automatic void check_field(input string name, input int k,
                                        input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s of field %0d: expected %h, got %h", $time, name, k, want, got);
        end
    endfunction

    // Advance the frame parse by one byte; queue fifteen values on a good frame
    task automatic take_rx_byte(input logic [7:0] b);
        logic [7:0] want;
        logic [7:0] sum;
        t_field f;
        int unsigned i;
        int k;
        if (hunt_pos < POS_LEN) begin
            case (hunt_pos)
                0:       want = SYNC_A;
                1:       want = SYNC_B;
                2:       want = CLASS_NAV;
                default: want = ID_PVT;
            endcase
            if (b == want) begin
                frame_bytes[hunt_pos] = b;
                hunt_pos++;
            end else begin
                hunt_pos = 0;
            end
        end else if (hunt_pos == POS_LEN) begin
            frame_bytes[hunt_pos] = b;
            frame_len = b;
            if (frame_len > len_limit || frame_len + 7 > STORE_DEPTH)
                hunt_pos = 0;
            else
                hunt_pos = POS_BODY;
        end else if (hunt_pos == frame_len + 7) begin
            hunt_pos = 0;
            sum = '0;
            for (i = POS_CLASS; i < frame_len + 6; i++)
                sum = sum + frame_bytes[i];
            if (sum == frame_bytes[frame_len + 6]) begin
                good_frames = good_frames + 1;
                for (k = 0; k < 14; k++) begin
                    f.index = t_fld_idx'(4'(k));
                    f.value = le_value(FIELD_START[k], (k < 2) ? 1 : (k == 13) ? 2 : 4);
                    f.last  = 1'b0;
                    expected_fields.push_back(f);
                end
                f.index = FLD_COUNT;
                f.value = good_frames;
                f.last  = 1'b1;
                expected_fields.push_back(f);
            end
        end else if (hunt_pos < frame_len + 7 && hunt_pos < STORE_DEPTH) begin
            frame_bytes[hunt_pos] = b;
            hunt_pos++;
        end else begin
            hunt_pos = 0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_field want_f;
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < STORE_DEPTH; i++)
                frame_bytes[i] = '0;
            hunt_pos    = 0;
            frame_len   = 0;
            good_frames = '0;
            len_limit   = MAX_LENGTH_RESET;
            expected_fields.delete();
        end else begin
            // Compare before predicting: a byte never yields a result in its own cycle
            if (i_res_valid && i_res_ready) begin
                if (expected_fields.size() == 0) begin
                    errors++;
                    $display("%0t: extra result: expected none, got index %0d value %h last %b",
                             $time, i_field_index, i_field_value, i_last_field);
                end else begin
                    want_f = expected_fields.pop_front();
                    check_field("field_index", want_f.index, 32'(want_f.index),
                                32'(i_field_index));
                    check_field("field_value", want_f.index, want_f.value, i_field_value);
                    check_field("last_field", want_f.index, 32'(want_f.last),
                                32'(i_last_field));
                end
            end
            // A byte taken at the edge of a write still sees the old limit
            if (i_rx_valid && i_rx_ready)
                take_rx_byte(i_rx_byte);
            if (i_cfg_we)
                len_limit = i_cfg_data;
        end
        o_errors  <= errors;
        o_pending <= expected_fields.size();
    end

endmodule

[tb/sv/nav_frame_parser_tb.sv]
`timescale 1ns / 1ps
// nav_frame_parser_tb: feeds byte frames and max_length settings into the
// frame parser and reports the verdict. Depends on nfp_pkg, the parser RTL
// and nav_frame_parser_checker, which does all prediction and comparison.
module nav_frame_parser_tb;
    import nfp_pkg::*;

    localparam int unsigned STORE_DEPTH = 128;
    localparam int IDLE_PCT        = 12;    // percent of cycles a side idles
    localparam int STALL_LIMIT     = 2000;  // cycles without any transfer
    localparam int BYTES_PER_PHASE = 84;
    localparam int SETTLE_CYCLES   = 20;
    localparam int WHOLE_FRAME     = 1024;  // keep count that sends the full frame
    localparam int HEADER_BYTES    = POS_LEN + 1;
    localparam int MAX_FIT_LEN     = STORE_DEPTH - 7;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_rx_byte  = '0;
    logic        i_ready    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_field_index;
    logic [31:0] o_field_value;
    logic        o_last_field;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int bytes_sent   = 0;
    int len_limit    = MAX_LENGTH_RESET;  // mirror of max_length for picking lengths
    bit steady       = 1'b0;              // suppress idling on both sides

    always #1 i_clk = ~i_clk;

    nav_frame_parser #(
        .STORE_DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_field_index (o_field_index),
        .o_field_value (o_field_value),
        .o_last_field  (o_last_field),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    nav_frame_parser_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_field_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_valid),
        .i_rx_ready    (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_field_index (o_field_index),
        .i_field_value (o_field_value),
        .i_last_field  (o_last_field),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (fail_count),
        .o_pending     (pending)
    );

    // Result side: drop ready at random, except during the steady phase
    always @(posedge i_clk)
        i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Watchdog: end the run if no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one byte and hold it until the transfer. Called at a rising edge;
    // returns at the edge of the transfer with valid still high.
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Build a frame with length byte len and send its first keep bytes.
    // Corrupt one bit of the first checksum byte when bad_sum is set.
    task automatic send_frame(input int len, input bit bad_sum, input int keep);
        logic [7:0] frame_q [$];
        logic [7:0] sum;
        logic [7:0] d;
        int i;
        frame_q.push_back(SYNC_A);
        frame_q.push_back(SYNC_B);
        frame_q.push_back(CLASS_NAV);
        frame_q.push_back(ID_PVT);
        frame_q.push_back(8'(len));
        d = 8'($urandom);
        frame_q.push_back(d);
        sum = CLASS_NAV + ID_PVT + 8'(len) + d;
        for (i = 0; i < len; i++) begin
            d = 8'($urandom);
            frame_q.push_back(d);
            sum = sum + d;
        end
        if (bad_sum)
            sum = sum ^ (8'd1 << $urandom_range(0, 7));
        frame_q.push_back(sum);
        frame_q.push_back(8'($urandom));  // second checksum byte is not checked
        for (i = 0; i < frame_q.size() && i < keep; i++)
            send_byte(frame_q[i]);
    endtask

    // Lower valid, wait for every expected result, then let the parser settle
    // (a frame with a bad checksum leaves nothing to wait on).
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input int v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 7'(v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        len_limit  = v;
    endtask

    // Mostly well-formed frames with random payloads, mostly short; the rest
    // are boundary lengths, rejected lengths, truncated frames and loose noise.
    task automatic random_phase();
        int start;
        int len;
        int keep;
        int r;
        bit bad;
        start = bytes_sent;
        send_frame(len_limit, 1'b0, WHOLE_FRAME);
        while (bytes_sent - start < BYTES_PER_PHASE) begin
            if ($urandom_range(0, 99) < 20)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            r    = $urandom_range(0, 99);
            keep = WHOLE_FRAME;
            bad  = ($urandom_range(0, 99) < 15);
            if (r < 8) begin
                len = len_limit;
            end else if (r < 14) begin
                len  = len_limit + 1;
                keep = HEADER_BYTES;
            end else if (r < 18) begin
                len  = $urandom_range(MAX_FIT_LEN + 1, 255);
                keep = HEADER_BYTES;
            end else if (r < 30) begin
                len = $urandom_range((len_limit < 78) ? len_limit : 78, len_limit);
            end else begin
                len = $urandom_range(0, (len_limit < 20) ? len_limit : 20);
                if (r < 35)
                    keep = $urandom_range(1, len + 7);
            end
            send_frame(len, bad, keep);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: shortest good frame, sync mismatch without a second look
        // at the mismatching byte, class mismatch, length one past the
        // reset limit, and a bad checksum.
        send_frame(0, 1'b0, WHOLE_FRAME);
        send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(8'h00);
        send_frame(MAX_LENGTH_RESET + 1, 1'b0, HEADER_BYTES);
        send_frame(0, 1'b1, WHOLE_FRAME);

        // Random traffic under the reset limit, then under each new setting
        random_phase();
        drain_results();
        write_limit(MAX_FIT_LEN);
        random_phase();
        drain_results();
        write_limit(0);
        random_phase();
        drain_results();
        write_limit(35);
        steady = 1'b1;   // hold both sides busy for a whole phase
        random_phase();
        steady = 1'b0;

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/nfp_pkg.sv
rtl/core/nfp_field_buf.sv
rtl/core/nav_frame_parser.sv
tb/sv/nav_frame_parser_checker.sv
tb/sv/nav_frame_parser_tb.sv
